@@ rtl/core/mrbt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrbt_pkg
// Shared types, codes and the ROM mirror layout for the bank translator.
// ----------------------------------------------------------------------------
package mrbt_pkg;

  typedef enum logic [1:0] {
    CMD_STORE = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_XLATE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_ROM  = 2'd1,
    KIND_WRAM = 2'd2,
    KIND_CARD = 2'd3
  } kind_t;

  localparam logic [1:0] CFG_ROM_COUNT = 2'd0;
  localparam logic [1:0] CFG_WRAM_BANKS = 2'd1;
  localparam logic [1:0] CFG_CARD_MODE = 2'd2;

  localparam logic [1:0] CARD_192K = 2'd1;
  localparam logic [1:0] CARD_32K = 2'd2;

  localparam logic [7:0] ROM_COUNT_384K = 8'h30;
  localparam logic [7:0] ROM_COUNT_512K = 8'h40;
  localparam logic [7:0] ROM_COUNT_768K = 8'h60;

  localparam logic [7:0] ROM_COUNT_RST = 8'd32;
  localparam logic [2:0] WRAM_BANKS_RST = 3'd1;
  localparam logic [1:0] CARD_MODE_RST = 2'd0;

  localparam int DIVIDEND_W = 7;
  localparam int OFFSET_W = 13;
  localparam int PHYS_W = 20;
  localparam int IN_TDATA_W = 40;
  localparam int OUT_TDATA_W = 40;

  typedef struct packed {
    logic load_in;
    logic start_div;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } dp_status_t;

  // start group (in units of 16 banks) for the 16-bank group of a ROM bank
  function automatic logic [2:0] layout_group(input logic [7:0] count,
                                              input logic [2:0] grp);
    logic [2:0] res;
    res = grp;
    if (count == ROM_COUNT_384K) begin
      res = grp[2] ? 3'd2 : {2'b00, grp[0]};
    end else if (count == ROM_COUNT_512K) begin
      res = {1'b0, (grp[2] | grp[1]), grp[0]};
    end else if (count == ROM_COUNT_768K) begin
      res = (grp[2] && grp[1]) ? {2'b10, grp[0]} : grp;
    end
    return res;
  endfunction

endpackage

@@ rtl/core/mrbt_urem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrbt_urem
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module mrbt_urem (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [mrbt_pkg::DIVIDEND_W-1:0]   dividend,
  input  logic [7:0]                        divisor,
  output logic                              done,
  output logic [7:0]                        remainder
);

  logic                            busy;
  logic [2:0]                      cnt;
  logic [mrbt_pkg::DIVIDEND_W-1:0] dvd;
  logic [7:0]                      dsr;
  logic [8:0]                      trial;
  logic [8:0]                      diff;
  logic                            ge;

  assign trial = {remainder, dvd[mrbt_pkg::DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= 3'(mrbt_pkg::DIVIDEND_W - 1);
    end else if (busy) begin
      cnt <= cnt - 3'd1;
      if (cnt == 3'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= dividend;
      dsr       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      dvd       <= {dvd[mrbt_pkg::DIVIDEND_W-2:0], 1'b0};
      remainder <= ge ? diff[7:0] : trial[7:0];
    end
  end

endmodule

@@ rtl/core/mrbt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrbt_ctrl
// Sequencer for one request at a time and the result valid flag.
// ----------------------------------------------------------------------------
module mrbt_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  input  mrbt_pkg::dp_status_t   status,
  output mrbt_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next    = state;
    cmd.load_in   = 1'b0;
    cmd.start_div = 1'b0;
    cmd.commit    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.need_div) begin
          cmd.start_div = 1'b1;
          state_next    = ST_DIV;
        end else if (out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/mrbt_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrbt_dp
// Mapping registers, transfer buffer, bank classification and result register.
// ----------------------------------------------------------------------------
module mrbt_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [mrbt_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic [mrbt_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                                cfg_valid,
  input  logic [1:0]                          cfg_index,
  input  logic [7:0]                          cfg_data,
  input  mrbt_pkg::ctrl_cmd_t                 cmd,
  output mrbt_pkg::dp_status_t                status
);

  logic [7:0] map_reg [8];
  logic [7:0] last_xfer;
  logic [7:0] rom_count;
  logic [2:0] wram_banks;
  logic [1:0] card_mode;

  mrbt_pkg::cmd_t cmd_q;
  logic [7:0]     mask_q;
  logic [7:0]     wval_q;
  logic [15:0]    addr_q;

  logic [7:0]                      bank;
  logic                            is_rom;
  logic                            is_wram;
  logic                            card_a;
  logic                            card_b;
  logic [7:0]                      card_a_idx;
  logic [7:0]                      rom_div;
  logic [2:0]                      wram_div;
  logic [2:0]                      grp;
  logic [mrbt_pkg::DIVIDEND_W-1:0] dividend;
  logic [7:0]                      divisor;
  logic                            div_done;
  logic [7:0]                      rem;
  logic [7:0]                      or_all;
  mrbt_pkg::kind_t                 kind;
  logic [mrbt_pkg::PHYS_W-1:0]     phys;

  logic [7:0]                  rd_out;
  logic [7:0]                  bank_out;
  mrbt_pkg::kind_t             kind_out;
  logic [mrbt_pkg::PHYS_W-1:0] phys_out;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_count  <= mrbt_pkg::ROM_COUNT_RST;
      wram_banks <= mrbt_pkg::WRAM_BANKS_RST;
      card_mode  <= mrbt_pkg::CARD_MODE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mrbt_pkg::CFG_ROM_COUNT:  rom_count  <= cfg_data;
        mrbt_pkg::CFG_WRAM_BANKS: wram_banks <= cfg_data[2:0];
        mrbt_pkg::CFG_CARD_MODE:  card_mode  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_q  <= mrbt_pkg::cmd_t'(s_tdata[1:0]);
      mask_q <= s_tdata[9:2];
      wval_q <= s_tdata[17:10];
      addr_q <= s_tdata[33:18];
    end
  end

  // classification
  assign bank       = map_reg[addr_q[15:13]];
  assign is_rom     = !bank[7];
  assign is_wram    = (bank[7:2] == 6'b111110);
  assign card_a     = (card_mode == mrbt_pkg::CARD_192K) && (bank >= 8'h68) && (bank <= 8'h7F);
  assign card_b     = (card_mode == mrbt_pkg::CARD_32K) && (bank >= 8'h40) && (bank <= 8'h5F);
  assign card_a_idx = bank - 8'h68;
  assign rom_div    = (rom_count == 8'd0) ? 8'd1 : rom_count;
  assign wram_div   = (wram_banks == 3'd0) ? 3'd1 : wram_banks;
  assign grp        = mrbt_pkg::layout_group(rom_div, bank[6:4]);
  assign dividend   = is_rom ? {grp, bank[3:0]} : {5'b00000, bank[1:0]};
  assign divisor    = is_rom ? rom_div : {5'b00000, wram_div};

  assign status.need_div = (cmd_q == mrbt_pkg::CMD_XLATE) && (is_rom || is_wram)
                           && !card_a && !card_b;
  assign status.div_done = div_done;

  mrbt_urem u_urem (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.start_div),
    .dividend  (dividend),
    .divisor   (divisor),
    .done      (div_done),
    .remainder (rem)
  );

  always_comb begin
    or_all = '0;
    for (int i = 0; i < 8; i++) begin
      if (mask_q[i]) or_all = or_all | map_reg[i];
    end
  end

  always_comb begin
    priority if (card_a) begin
      kind = mrbt_pkg::KIND_CARD;
      phys = {2'b00, card_a_idx[4:0], addr_q[12:0]};
    end else if (card_b) begin
      kind = mrbt_pkg::KIND_CARD;
      phys = {5'b00000, bank[1:0], addr_q[12:0]};
    end else if (is_rom) begin
      kind = mrbt_pkg::KIND_ROM;
      phys = {rem[6:0], addr_q[12:0]};
    end else if (is_wram) begin
      kind = mrbt_pkg::KIND_WRAM;
      phys = {rem[6:0], addr_q[12:0]};
    end else begin
      kind = mrbt_pkg::KIND_NONE;
      phys = '0;
    end
  end

  // state update on commit
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) map_reg[i] <= '0;
      last_xfer <= '0;
    end else if (cmd.commit) begin
      if (cmd_q == mrbt_pkg::CMD_STORE && mask_q != 8'd0) begin
        last_xfer <= wval_q;
        for (int i = 0; i < 8; i++) begin
          if (mask_q[i]) map_reg[i] <= wval_q;
        end
      end else if (cmd_q == mrbt_pkg::CMD_LOAD && mask_q != 8'd0) begin
        last_xfer <= or_all;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      unique case (cmd_q)
        mrbt_pkg::CMD_LOAD: begin
          rd_out   <= (mask_q == 8'd0) ? last_xfer : or_all;
          bank_out <= '0;
          kind_out <= mrbt_pkg::KIND_NONE;
          phys_out <= '0;
        end
        mrbt_pkg::CMD_XLATE: begin
          rd_out   <= '0;
          bank_out <= bank;
          kind_out <= kind;
          phys_out <= phys;
        end
        default: begin
          rd_out   <= '0;
          bank_out <= '0;
          kind_out <= mrbt_pkg::KIND_NONE;
          phys_out <= '0;
        end
      endcase
    end
  end

  assign m_tdata = {2'b00, phys_out, kind_out, bank_out, rd_out};

endmodule

@@ rtl/core/mapping_register_bank_translator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mapping_register_bank_translator_unit
// Eight bank mapping registers with store, load and address translation.
// ----------------------------------------------------------------------------
// Requests enter on the s_ group, results leave on the m_ group; each request
// gives exactly one result. Configuration writes use cfg_valid/cfg_index/
// cfg_data and are always ready (0 ROM bank count, 1 work RAM banks,
// 2 card RAM mode).
// One request is handled at a time. Store, load and translations that hit
// card RAM or unmapped banks go from the idle state to the execute state and
// commit the result there. ROM and work RAM translations pass through the
// divide and done states before the commit: the bank mirror is a remainder
// by the configured bank count, worked out one bit per cycle in the
// remainder unit.
// The result sits in an output register; the next request is accepted while
// it waits, and that request finishes once the receiver takes the old one.
// Reset clears the mapping registers and transfer buffer and restores the
// default configuration (32 ROM banks, 1 work RAM bank, no card RAM).
// ----------------------------------------------------------------------------
module mapping_register_bank_translator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // command[1:0], select_mask[9:2], write_value[17:10], logical_address[33:18]
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_data[7:0], bank_number[15:8], memory_kind[17:16],
  // physical_offset[37:18]
  output logic [39:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  mrbt_pkg::ctrl_cmd_t  cmd;
  mrbt_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  mrbt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mrbt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

@@ rtl/core/mrbt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrbt_checker
// Port-level checks for the bank translator, bound to the top level.
// ----------------------------------------------------------------------------
module mrbt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [39:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  a_unmapped_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[17:16] == 2'd0 |-> m_tdata[37:18] == 20'd0)
    else $error("offset nonzero on unmapped result");

endmodule

bind mapping_register_bank_translator_unit mrbt_checker u_mrbt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
